/* rtl/crc8fd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the CRC-8 byte update for the frame deframer.
// No dependencies; used by crc8fd_win and crc8_frame_deframer.
package crc8fd_pkg;

	localparam int unsigned WinLen   = 16;
	localparam int unsigned HistLen  = WinLen - 1;
	localparam int unsigned CrcSpan  = 13;
	localparam int unsigned HoldW    = 4;
	localparam logic [7:0]  CrcPoly  = 8'h31;
	localparam logic [HoldW-1:0] SkipCount = 4'd15;

	localparam logic [7:0] StartReset = 8'hFF;
	localparam logic [7:0] EndReset   = 8'h00;

	// configuration register indexes
	localparam logic CfgStartByte = 1'b0;
	localparam logic CfgEndByte   = 1'b1;

	typedef struct packed {
		logic [47:0] data_second;
		logic [47:0] data_first;
		logic [7:0]  command;
	} frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} result_t;

	// One byte through CRC-8, MSB first.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] din);
		logic [7:0] c;
		c = crc ^ din;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/crc8fd_win.sv */
`timescale 1ns / 1ps
// Byte window, running partial CRCs, skip counter and frame decision.
// Depends on crc8fd_pkg.
module crc8fd_win (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [7:0]            rx_byte,
	input  logic [7:0]            start_byte,
	input  logic [7:0]            end_byte,
	output crc8fd_pkg::result_t   result
);

	logic [7:0] hist_q [crc8fd_pkg::HistLen];
	// part_q[k] holds the CRC of the last k+1 accepted bytes
	logic [7:0] part_q [crc8fd_pkg::CrcSpan];
	logic [7:0] crc_d_q;
	logic [crc8fd_pkg::HoldW-1:0] holdoff_q;

	logic cand;
	logic crc_ok;

	assign cand   = (holdoff_q == '0) && (hist_q[0] == start_byte) && (rx_byte == end_byte);
	assign crc_ok = (crc_d_q == hist_q[crc8fd_pkg::HistLen-1]);

	always_comb begin
		result.valid             = accept && cand && crc_ok;
		result.frame.command     = hist_q[1];
		result.frame.data_first  = {hist_q[7], hist_q[6], hist_q[5],
		                            hist_q[4], hist_q[3], hist_q[2]};
		result.frame.data_second = {hist_q[13], hist_q[12], hist_q[11],
		                            hist_q[10], hist_q[9], hist_q[8]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < crc8fd_pkg::HistLen; i++) begin
				hist_q[i] <= '0;
			end
			for (int k = 0; k < crc8fd_pkg::CrcSpan; k++) begin
				part_q[k] <= '0;
			end
			crc_d_q   <= '0;
			holdoff_q <= crc8fd_pkg::SkipCount;
		end else if (accept) begin
			for (int i = 0; i < crc8fd_pkg::HistLen - 1; i++) begin
				hist_q[i] <= hist_q[i+1];
			end
			hist_q[crc8fd_pkg::HistLen-1] <= rx_byte;
			part_q[0] <= crc8fd_pkg::crc8_update(8'h00, rx_byte);
			for (int k = 1; k < crc8fd_pkg::CrcSpan; k++) begin
				part_q[k] <= crc8fd_pkg::crc8_update(part_q[k-1], rx_byte);
			end
			// hold the CRC over the span that ends one byte earlier
			crc_d_q <= part_q[crc8fd_pkg::CrcSpan-1];
			if (holdoff_q != '0) begin
				holdoff_q <= holdoff_q - 4'd1;
			end else if (cand) begin
				holdoff_q <= crc8fd_pkg::SkipCount;
			end
		end
	end

endmodule

/* rtl/crc8_frame_deframer.sv */
`timescale 1ns / 1ps
// CRC-8 frame deframer: top level with the output register and skid stage.
// Depends on crc8fd_pkg and crc8fd_win.
//
// Usage:
//   Input bytes arrive on s_axis_* one request at a time. Each byte closes a
//   16-byte window; when the window starts with start_byte, ends with
//   end_byte and its CRC-8 (poly 0x31) over bytes 1..13 equals byte 14, one
//   frame leaves on m_axis_* with the command and twelve data bytes.
//   After a candidate window the next 15 positions are not checked.
//   A frame is registered in out_q, or in the skid while out_q stalls.
//   Throughput: one byte per cycle while the skid is empty; the window shift,
//   thirteen parallel CRC byte updates and the compare all run on accept.
//   A stalled receiver: the output register plus a one-entry skid buffer
//   keep input flowing; s_axis_tready drops only while the skid is occupied.
//   Configuration: cfg_* writes start_byte (index 0) or end_byte (index 1);
//   always ready, write only while the stream is idle.
//   Reset: window and partial CRCs clear to zero, registers take 0xFF/0x00,
//   the first check falls on the sixteenth byte, pending frames are dropped.
module crc8_frame_deframer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [103:0]  m_axis_tdata,   // [7:0] command, [55:8] data_first,
	                                      // [103:56] data_second
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_index,
	input  logic [7:0]    cfg_data
);

	logic [7:0] start_byte_q;
	logic [7:0] end_byte_q;

	logic                out_valid_q;
	crc8fd_pkg::frame_t  out_q;
	logic                skid_valid_q;
	crc8fd_pkg::frame_t  skid_q;

	logic                accept;
	crc8fd_pkg::result_t res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !skid_valid_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	crc8fd_win u_win (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (s_axis_tdata),
		.start_byte (start_byte_q),
		.end_byte   (end_byte_q),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= crc8fd_pkg::StartReset;
			end_byte_q   <= crc8fd_pkg::EndReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				crc8fd_pkg::CfgStartByte: start_byte_q <= cfg_data;
				crc8fd_pkg::CfgEndByte:   end_byte_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || m_axis_tready) begin
				// advance: skid first, then a fresh frame
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= res.valid;
				end else begin
					out_valid_q  <= res.valid;
				end
			end else if (res.valid) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_axis_tready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (res.valid) begin
					skid_q <= res.frame;
				end
			end else if (res.valid) begin
				out_q <= res.frame;
			end
		end else if (res.valid) begin
			skid_q <= res.frame;
		end
	end

endmodule

/* test/crc8_frame_deframer_check.sv */
`timescale 1ns / 1ps
// Checker for crc8_frame_deframer: watches the byte, frame and register channels,
// predicts the frames each byte completes, and compares them in order.
// Depends on crc8fd_pkg for the frame layout, register indexes and reset values.
module crc8_frame_deframer_check
	import crc8fd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [103:0] m_axis_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [7:0]   cfg_data,
	output int           errors,
	output int           pending,
	output int           frames_matched
);

	logic [7:0]       sync_start;
	logic [7:0]       sync_end;
	logic [7:0]       recent [HistLen];
	logic [HoldW-1:0] skip_left;
	frame_t           frames_due [$];
	int               printed;

	// Bit-serial CRC-8, MSB first.
	function automatic logic [7:0] crc8_bits(input logic [7:0] crc, input logic [7:0] din);
		logic [7:0] r;
		logic       fb;
		r = crc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ din[i];
			r = {r[6:0], 1'b0};
			if (fb) begin
				r = r ^ CrcPoly;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		if (printed < 30) begin
			$display("mismatch at %0t ns: %s", $time, what);
			printed++;
		end
	endtask

	// Slide the window by one received byte and queue the frame it closes, if any.
	task automatic advance_window(input logic [7:0] rx);
		logic [7:0] crc;
		frame_t     f;
		if (skip_left != 0) begin
			skip_left = skip_left - 1'b1;
		end else if (recent[0] == sync_start && rx == sync_end) begin
			// reload the skip even when the CRC fails
			skip_left = SkipCount;
			crc = 8'h00;
			for (int k = 1; k <= CrcSpan; k++) begin
				crc = crc8_bits(crc, recent[k]);
			end
			if (crc == recent[HistLen-1]) begin
				f.command = recent[1];
				for (int k = 0; k < 6; k++) begin
					f.data_first[8*k +: 8]  = recent[2+k];
					f.data_second[8*k +: 8] = recent[8+k];
				end
				frames_due.push_back(f);
			end
		end
		for (int k = 0; k < HistLen-1; k++) begin
			recent[k] = recent[k+1];
		end
		recent[HistLen-1] = rx;
	endtask

	task automatic check_frame(input frame_t got);
		frame_t want;
		if (frames_due.size() == 0) begin
			report_mismatch($sformatf("frame with no request behind it: %h", got));
			return;
		end
		want = frames_due.pop_front();
		if (got.command !== want.command) begin
			report_mismatch($sformatf("command %h, want %h", got.command, want.command));
		end
		if (got.data_first !== want.data_first) begin
			report_mismatch($sformatf("data_first %h, want %h",
				got.data_first, want.data_first));
		end
		if (got.data_second !== want.data_second) begin
			report_mismatch($sformatf("data_second %h, want %h",
				got.data_second, want.data_second));
		end
		if (got === want) begin
			frames_matched++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_start = StartReset;
			sync_end   = EndReset;
			skip_left  = SkipCount;
			foreach (recent[k]) begin
				recent[k] = 8'h00;
			end
			frames_due.delete();
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_frame(m_axis_tdata);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CfgStartByte: sync_start = cfg_data;
					CfgEndByte:   sync_end   = cfg_data;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_window(s_axis_tdata);
			end
			pending <= frames_due.size();
		end
	end

endmodule

/* test/crc8_frame_deframer_test.sv */
`timescale 1ns / 1ps
// Top of the crc8_frame_deframer test: clock, reset, byte stream and register writes.
// Depends on crc8fd_pkg, the deframer RTL and crc8_frame_deframer_check.
module crc8_frame_deframer_test;
	import crc8fd_pkg::*;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata  = 8'h00;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [103:0] m_axis_tdata;
	logic         cfg_valid     = 1'b0;
	logic         cfg_ready;
	logic         cfg_index     = CfgStartByte;
	logic [7:0]   cfg_data      = 8'h00;

	int errors;
	int pending;
	int frames_matched;
	int bytes_sent         = 0;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;

	crc8_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	crc8_frame_deframer_check check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.pending(pending),
		.frames_matched(frames_matched)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	// Send a 16-byte frame; a nonzero crc_flip corrupts the check byte.
	task automatic send_frame(input logic [7:0] sof, input logic [7:0] eof,
			input logic [7:0] cmd, input logic [95:0] payload, input logic [7:0] crc_flip);
		logic [7:0] crc;
		crc = crc8_update(8'h00, cmd);
		for (int k = 0; k < 12; k++) begin
			crc = crc8_update(crc, payload[8*k +: 8]);
		end
		send_byte(sof);
		send_byte(cmd);
		for (int k = 0; k < 12; k++) begin
			send_byte(payload[8*k +: 8]);
		end
		send_byte(crc ^ crc_flip);
		send_byte(eof);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [95:0] pick_payload();
		logic [95:0] p;
		for (int k = 0; k < 12; k++) begin
			p[8*k +: 8] = pick_byte();
		end
		return p;
	endfunction

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Hold the stream until every predicted frame has left, then let the pipe settle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Mostly well-formed frames, with corrupted frames and noise mixed in.
	task automatic random_traffic(input int budget, input logic [7:0] sof, input logic [7:0] eof);
		int         first;
		int         sel;
		logic [7:0] flip;
		first = bytes_sent;
		while (bytes_sent - first < budget) begin
			sel  = $urandom_range(99);
			flip = 8'($urandom_range(255, 1));
			if (sel < 60) begin
				send_frame(sof, eof, pick_byte(), pick_payload(), 8'h00);
			end else if (sel < 70) begin
				send_frame(sof, eof, pick_byte(), pick_payload(), flip);
			end else if (sel < 78) begin
				send_frame(sof, eof ^ flip, pick_byte(), pick_payload(), 8'h00);
			end else begin
				repeat ($urandom_range(20, 1)) begin
					case ($urandom_range(5))
						0:       send_byte(sof);
						1:       send_byte(eof);
						default: send_byte(pick_byte());
					endcase
				end
			end
		end
	endtask

	task automatic run_phase(input logic [7:0] sof, input logic [7:0] eof,
			input int idle_pct, input int stall_pct);
		drain();
		write_reg(CfgStartByte, sof);
		write_reg(CfgEndByte, eof);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		random_traffic(115, sof, eof);
		drain();
		random_traffic(115, sof, eof);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values; the first frame lands on the first full window
		send_frame(StartReset, EndReset, 8'h00, 96'h0, 8'h00);
		send_frame(StartReset, EndReset, 8'hFF, {96{1'b1}}, 8'h00);
		send_frame(StartReset, EndReset, 8'h5A, 96'h0C0B0A090807060504030201, 8'h80);
		send_frame(StartReset, EndReset, 8'h80, 96'h0C0B0A090807060504030201, 8'h00);
		random_traffic(170, StartReset, EndReset);

		run_phase(8'h00, 8'hFF, 83, 0);
		run_phase(8'hA5, 8'h3C, 0, 83);
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 31, 31);
		run_phase(8'h7E, 8'h7E, 0, 0);

		drain();
		repeat (8) @(posedge clk);
		$display("sent %0d bytes over five register settings and idle/stall mixes", bytes_sent);
		$display("frames matched: %0d", frames_matched);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#6_000_000;
		$display("run limit reached with %0d frames outstanding", pending);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* crc8_frame_deframer.f */
rtl/crc8fd_pkg.sv
rtl/crc8fd_win.sv
rtl/crc8_frame_deframer.sv
test/crc8_frame_deframer_check.sv
test/crc8_frame_deframer_test.sv
